/* design/token_bucket_rate_limiter_macros.svh */
// Assertion macros used by the token bucket rate limiter module.
`ifndef TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TBRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tbrl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tbrl_pkg;

  // Number of client buckets; must be a power of two so that the client
  // index wraps by dropping its upper bits.
  localparam int CLIENT_COUNT  = 256;
  localparam int CLIENT_IDX_W  = $clog2(CLIENT_COUNT);
  localparam int CLIENT_FLD_W  = 8;
  localparam int FRACTION_BITS = 16;
  localparam int MAXTOK_W      = 12;
  localparam int RATE_W        = 28;
  localparam int TIME_W        = 32;
  localparam int LEVEL_W       = MAXTOK_W + FRACTION_BITS;
  localparam int PROD_W        = TIME_W + RATE_W;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE =
    {{(MAXTOK_W-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

  // Configuration register map.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE = 2'd1;

  localparam logic [MAXTOK_W-1:0] MAX_TOKENS_RST  = 12'd100;
  localparam logic [RATE_W-1:0]   REFILL_RATE_RST = 28'd109227;

  typedef struct packed {
    logic [CLIENT_FLD_W-1:0] client_index;
    logic [TIME_W-1:0]       time_now;
  } in_req_t;

  typedef struct packed {
    logic                allowed;
    logic [MAXTOK_W-1:0] used_count;
  } out_res_t;

  typedef struct packed {
    logic                    en;
    logic [CLIENT_IDX_W-1:0] idx;
    logic [LEVEL_W-1:0]      level;
    logic [TIME_W-1:0]       last_time;
  } mem_wr_t;

  typedef struct packed {
    logic               seen;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  last_time;
  } mem_rd_t;

  typedef struct packed {
    logic diff_en;
    logic mul_en;
    logic adj_en;
  } dp_ctrl_t;

endpackage

`default_nettype wire

/* design/token_bucket_rate_limiter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Per-client token bucket policer.
// A request is offered on in_req (client index and time in seconds) with
// start; it is taken at a rising edge where start is high and busy is low.
// Each request yields exactly one result on out_res, shown for one cycle
// with out_valid high; the receiver has no way to hold it off.
// The result strobe comes after the per-request sequence: bucket memory
// read, elapsed time, refill multiply, add and cap, then token take and
// memory write back. A new request can be taken at the end of the strobe
// cycle; the block takes no new request while one is in flight.
// Configuration goes through cfg_valid/cfg_ready with cfg_index selecting
// max_tokens (0) or refill_rate (1); other indexes are ignored. Writes are
// expected only while the block is idle.
// Synchronous active-low reset restores the default capacity and rate and
// marks every client as unseen, so each client starts with a full bucket.
// No memory clearing pass is needed after reset.
module token_bucket_rate_limiter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire tbrl_pkg::in_req_t                in_req,
  output logic                                  out_valid,
  output tbrl_pkg::out_res_t                    out_res,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tbrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tbrl_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "token_bucket_rate_limiter_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_ADJ, S_DONE} state_t;

  state_t                          state_r;
  tbrl_pkg::in_req_t               req_r;
  logic                            out_valid_r;
  tbrl_pkg::out_res_t              out_res_r;
  logic [tbrl_pkg::MAXTOK_W-1:0]   max_tokens_r;
  logic [tbrl_pkg::RATE_W-1:0]     refill_rate_r;

  logic                            accept;
  tbrl_pkg::mem_wr_t               wr;
  tbrl_pkg::mem_rd_t               rd;
  tbrl_pkg::dp_ctrl_t              ctrl;
  logic [tbrl_pkg::LEVEL_W-1:0]    level_adj;
  logic                            allowed;
  logic [tbrl_pkg::LEVEL_W-1:0]    level_new;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration registers. Unknown indexes leave both unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r  <= tbrl_pkg::MAX_TOKENS_RST;
      refill_rate_r <= tbrl_pkg::REFILL_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbrl_pkg::CFG_MAX_TOKENS: begin
          max_tokens_r <= cfg_data[tbrl_pkg::MAXTOK_W-1:0];
        end
        tbrl_pkg::CFG_REFILL_RATE: begin
          refill_rate_r <= cfg_data[tbrl_pkg::RATE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The bucket state is read at the accepting edge; the data is ready in
  // the READ cycle.
  tbrl_state_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .rd_idx (in_req.client_index[tbrl_pkg::CLIENT_IDX_W-1:0]),
    .wr     (wr),
    .rd     (rd)
  );

  always_comb begin
    ctrl.diff_en = (state_r == S_READ);
    ctrl.mul_en  = (state_r == S_MUL);
    ctrl.adj_en  = (state_r == S_ADJ);
  end

  tbrl_bucket_dp u_dp (
    .clk         (clk),
    .ctrl        (ctrl),
    .rd          (rd),
    .time_now    (req_r.time_now),
    .max_tokens  (max_tokens_r),
    .refill_rate (refill_rate_r),
    .level_adj   (level_adj)
  );

  // A request passes when at least one whole token is left after refill.
  always_comb begin
    allowed   = (level_adj >= tbrl_pkg::LEVEL_ONE);
    level_new = allowed ? (level_adj - tbrl_pkg::LEVEL_ONE) : level_adj;
  end

  // Write back happens in the last cycle, so the next request, which is
  // accepted no earlier than the following edge, always sees fresh state.
  always_comb begin
    wr.en        = (state_r == S_DONE);
    wr.idx       = req_r.client_index[tbrl_pkg::CLIENT_IDX_W-1:0];
    wr.level     = level_new;
    wr.last_time = req_r.time_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r   <= in_req;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ADJ;
        end
        S_ADJ: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r          <= 1'b1;
          out_res_r.allowed    <= allowed;
          out_res_r.used_count <= max_tokens_r
                                  - level_new[tbrl_pkg::LEVEL_W-1:tbrl_pkg::FRACTION_BITS];
          state_r              <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `TBRL_ASSERT_NEXT(a_accept_reads, clk, rst_n, accept, state_r == S_READ,
                    "accept did not start a read")
  `TBRL_ASSERT_NEXT(a_done_strobes, clk, rst_n, state_r == S_DONE, out_valid_r && !busy,
                    "finished request gave no result")
  `TBRL_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid_r, state_r == S_IDLE && $past(wr.en),
                   "result without write back")
  `TBRL_ASSERT_NOW(a_write_once, clk, rst_n, wr.en, $past(state_r) == S_ADJ,
                   "write back outside request end")

endmodule

`default_nettype wire

/* design/tbrl_state_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

// Per-client bucket store: level and last time in a synchronous memory,
// seen flags in flip-flops so that reset marks every client unseen at once.
module tbrl_state_mem (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            rd_en,
  input  wire logic [tbrl_pkg::CLIENT_IDX_W-1:0] rd_idx,
  input  wire tbrl_pkg::mem_wr_t               wr,
  output tbrl_pkg::mem_rd_t                    rd
);

  logic [tbrl_pkg::LEVEL_W-1:0] level_mem [tbrl_pkg::CLIENT_COUNT];
  logic [tbrl_pkg::TIME_W-1:0]  time_mem  [tbrl_pkg::CLIENT_COUNT];
  logic [tbrl_pkg::CLIENT_COUNT-1:0] seen_r;
  logic                         seen_rd_r;
  logic [tbrl_pkg::LEVEL_W-1:0] level_rd_r;
  logic [tbrl_pkg::TIME_W-1:0]  time_rd_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      level_mem[wr.idx] <= wr.level;
      time_mem[wr.idx]  <= wr.last_time;
    end
    if (rd_en) begin
      level_rd_r <= level_mem[rd_idx];
      time_rd_r  <= time_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      seen_rd_r <= 1'b0;
    end else begin
      if (wr.en) begin
        seen_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        seen_rd_r <= seen_r[rd_idx];
      end
    end
  end

  assign rd = '{seen: seen_rd_r, level: level_rd_r, last_time: time_rd_r};

endmodule

`default_nettype wire

/* design/tbrl_bucket_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

// Refill datapath: elapsed time, refill product, then add or subtract and cap.
module tbrl_bucket_dp (
  input  wire logic                          clk,
  input  wire tbrl_pkg::dp_ctrl_t            ctrl,
  input  wire tbrl_pkg::mem_rd_t             rd,
  input  wire logic [tbrl_pkg::TIME_W-1:0]   time_now,
  input  wire logic [tbrl_pkg::MAXTOK_W-1:0] max_tokens,
  input  wire logic [tbrl_pkg::RATE_W-1:0]   refill_rate,
  output logic [tbrl_pkg::LEVEL_W-1:0]       level_adj
);

  localparam int SUM_W = tbrl_pkg::PROD_W + 1;

  logic                          seen_r;
  logic                          back_r;
  logic [tbrl_pkg::TIME_W-1:0]   diff_r;
  logic [tbrl_pkg::LEVEL_W-1:0]  level_r;
  logic [tbrl_pkg::PROD_W-1:0]   prod_r;
  logic [tbrl_pkg::LEVEL_W-1:0]  level_adj_r;

  logic                          back_nxt;
  logic [tbrl_pkg::TIME_W-1:0]   diff_nxt;
  logic [tbrl_pkg::LEVEL_W-1:0]  cap;
  logic [tbrl_pkg::LEVEL_W-1:0]  drained;
  logic [SUM_W-1:0]              pre_cap;
  logic [tbrl_pkg::LEVEL_W-1:0]  level_adj_nxt;

  always_comb begin
    back_nxt = time_now < rd.last_time;
    diff_nxt = back_nxt ? (rd.last_time - time_now) : (time_now - rd.last_time);
  end

  always_comb begin
    cap = {max_tokens, {tbrl_pkg::FRACTION_BITS{1'b0}}};
    // Backward time drains the bucket and floors it at zero.
    drained = (prod_r >= tbrl_pkg::PROD_W'(level_r)) ? '0 :
              (level_r - prod_r[tbrl_pkg::LEVEL_W-1:0]);
    pre_cap = back_r ? SUM_W'(drained) : (SUM_W'(level_r) + SUM_W'(prod_r));
    if (!seen_r) begin
      level_adj_nxt = cap;
    end else if (pre_cap > SUM_W'(cap)) begin
      level_adj_nxt = cap;
    end else begin
      level_adj_nxt = pre_cap[tbrl_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      seen_r  <= rd.seen;
      back_r  <= back_nxt;
      diff_r  <= diff_nxt;
      level_r <= rd.level;
    end
    if (ctrl.mul_en) begin
      prod_r <= tbrl_pkg::PROD_W'(diff_r) * tbrl_pkg::PROD_W'(refill_rate);
    end
    if (ctrl.adj_en) begin
      level_adj_r <= level_adj_nxt;
    end
  end

  assign level_adj = level_adj_r;

endmodule

`default_nettype wire
